/* design/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
`default_nettype none
package lpht_pkg;
    localparam int KEY_W = 34;
    localparam int VAL_W = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;
    localparam int CMP_W = 5;
    localparam int CFG_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_INS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_REPL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_STORED = 2'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word, start modulo
        logic mod_step;    // one restoring division step
        logic probe_init;  // cursor = home, count = 0
        logic advance;     // cursor = cursor+1 wrap, count+1
        logic wr_new;      // write new entry at cursor
        logic wr_evict;    // write evicted entry at cursor
        logic ek_mod;      // start modulo of the read key
        logic evict_cap;   // capture read entry as evicted
        logic res_store;   // result: stored at cursor
        logic res_drop;    // result: dropped, slot 0
        logic res_drop_h;  // result: dropped, slot home
        logic res_store_h; // result: stored, slot home
        logic res_found;
        logic res_miss;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic [FUNC_W-1:0] func;
        logic cur_valid;   // valid bit at cursor
        logic key_hit;     // read key equals input key
        logic rd_home;     // read key hashes to home
        logic last;        // count reached n-1
    } t_stat;
endpackage
`default_nettype wire

/* design/lpht_if.sv */
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface lpht_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/linear_probing_hash_table.sv */
// Top level of the linear probing hash table.
// Open-addressed table of SLOTS (key, value) entries with linear probing and
// optional replacement on insert. For every word the home slot is key mod n,
// found by a bit-serial restoring modulo (one key bit per cycle over all 34
// key bits, then a done state); an insert then reads home and checks it.
// Every further probed or searched slot passes a read and a check through the
// registered slot memory read, and a probe that finds no free slot ends in the
// read state. Insert with replacement runs a second modulo on the home
// occupant's key. The controller passes a wait state before it returns to
// idle. One word is in work at a time; a finished result waits in the output
// register, and the next word is accepted only once that result leaves or is
// leaving.
`default_nettype none
module linear_probing_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              cfg_we,
    input  wire [CFG_W-1:0]  cfg_wdata,
    lpht_if.sink             s_in,
    lpht_if.source           m_out
);
    logic [CFG_W-1:0] r_table_size;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_res_valid;
    logic  w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_table_size <= CFG_W'(16);
        else if (cfg_we) r_table_size <= cfg_wdata;
    end

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .o_in_ready (w_in_ready),
        .i_res_free (!w_res_valid || m_out.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpht_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_table_size  (r_table_size),
        .i_func        (s_in.data.func),
        .i_key         (s_in.data.key),
        .i_value       (s_in.data.value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_res_take    (m_out.ready),
        .o_res_valid   (w_res_valid),
        .o_status      (m_out.data.status),
        .o_slot        (m_out.data.slot),
        .o_found_value (m_out.data.found_value),
        .o_comparisons (m_out.data.comparisons)
    );

    assign s_in.ready  = w_in_ready;
    assign m_out.valid = w_res_valid;

    a_one_cmd_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr_new && w_cmd.wr_evict)) else $error("two slot writes at once");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready) |=> !s_in.ready) else $error("accepted while busy");
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_found |=> (m_out.data.status == ST_FOUND && m_out.data.comparisons != '0))
        else $error("found result malformed");
endmodule
`default_nettype wire

/* design/lpht_ctrl.sv */
// Controller state machine sequencing modulo, probe and write steps.
`default_nettype none
module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  wire   i_res_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MOD   = 10'b0000000010,
        S_HOME  = 10'b0000000100,
        S_HCHK  = 10'b0000001000,
        S_EMOD  = 10'b0000010000,
        S_EDEC  = 10'b0000100000,
        S_PRD   = 10'b0001000000,
        S_PCHK  = 10'b0010000000,
        S_SCHK  = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_evict, n_evict;

    assign o_in_ready = (r_state == S_IDLE) && i_res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_evict <= 1'b0;
        end else begin
            r_state <= n_state;
            r_evict <= n_evict;
        end
    end

    always_comb begin
        n_state = r_state;
        n_evict = r_evict;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_evict = 1'b0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state = S_HOME;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_HOME: begin
                if (i_stat.func == FUNC_SEARCH) n_state = S_SCHK;
                else if (i_stat.func == FUNC_INS || i_stat.func == FUNC_INS_REPL)
                    n_state = S_HCHK;
                else begin
                    o_cmd.res_miss = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_HCHK: begin
                if (!i_stat.cur_valid) begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.res_store = 1'b1;
                    n_state = S_WAIT;
                end else if (i_stat.func == FUNC_INS) begin
                    n_state = S_PRD;
                end else begin
                    o_cmd.ek_mod = 1'b1;
                    n_state = S_EMOD;
                end
            end
            S_EMOD: begin
                if (i_stat.mod_done) n_state = S_EDEC;
                else o_cmd.mod_step = 1'b1;
            end
            S_EDEC: begin
                if (!i_stat.rd_home) begin
                    o_cmd.evict_cap = 1'b1;
                    o_cmd.wr_new = 1'b1;
                    n_evict = 1'b1;
                end
                n_state = S_PRD;
            end
            S_PRD: begin
                if (i_stat.last) begin
                    if (r_evict) o_cmd.res_drop_h = 1'b1;
                    else o_cmd.res_drop = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (!i_stat.cur_valid) begin
                    if (r_evict) begin
                        o_cmd.wr_evict = 1'b1;
                        o_cmd.res_store_h = 1'b1;
                    end else begin
                        o_cmd.wr_new = 1'b1;
                        o_cmd.res_store = 1'b1;
                    end
                    n_state = S_WAIT;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_SCHK: begin
                if (i_stat.cur_valid && i_stat.key_hit) begin
                    o_cmd.res_found = 1'b1;
                    n_state = S_WAIT;
                end else if (i_stat.last) begin
                    o_cmd.res_miss = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_HOME;
                end
            end
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* design/lpht_dp.sv */
// Datapath: slot memories, valid bits, serial modulo, probe cursor and result.
`default_nettype none
module lpht_dp
    import lpht_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [CFG_W-1:0]   i_table_size,
    input  wire  [FUNC_W-1:0]  i_func,
    input  wire  [KEY_W-1:0]   i_key,
    input  wire  [VAL_W-1:0]   i_value,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  wire                i_res_take,
    output logic               o_res_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [VAL_W-1:0]   o_found_value,
    output logic [CMP_W-1:0]   o_comparisons
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int MC = $clog2(KEY_W + 1);

    logic [KEY_W-1:0]  r_mem_key [SLOTS];
    logic [VAL_W-1:0]  r_mem_val [SLOTS];
    logic [SLOTS-1:0]  r_valid;
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;

    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [KEY_W-1:0]  r_ek;
    logic [VAL_W-1:0]  r_ev;
    logic [NW-1:0]     r_n;
    logic [IW-1:0]     r_home, r_cur, r_cnt;
    logic [KEY_W-1:0]  r_dq;
    logic [NW-1:0]     r_rem;
    logic [MC-1:0]     r_mcnt;
    logic              r_mbusy;

    logic [NW-1:0]     w_n;
    logic [NW:0]       w_trial;
    logic [IW-1:0]     w_nxt;
    logic              w_we;
    logic [KEY_W-1:0]  w_wk;
    logic [VAL_W-1:0]  w_wv;

    always_comb begin
        if (i_table_size == '0) w_n = NW'(1);
        else if ({{(NW > CFG_W ? NW - CFG_W : 0){1'b0}}, i_table_size} > (NW > CFG_W ? NW : CFG_W)'(SLOTS))
            w_n = NW'(SLOTS);
        else w_n = NW'(i_table_size);
    end

    // restoring modulo, one key bit per cycle
    assign w_trial = {r_rem, r_dq[KEY_W-1]} - {1'b0, r_n};
    assign w_nxt = (r_cur == IW'(r_n - NW'(1))) ? '0 : r_cur + IW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.load || i_cmd.ek_mod) begin
            r_mbusy <= 1'b1;
        end else if (i_cmd.mod_step && r_mcnt == MC'(KEY_W - 1)) begin
            r_mbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_val  <= i_value;
            r_n    <= w_n;
            r_dq   <= i_key;
        end else if (i_cmd.ek_mod) begin
            r_dq   <= r_rd_key;
        end else if (i_cmd.mod_step) begin
            r_dq   <= {r_dq[KEY_W-2:0], 1'b0};
        end
        if (i_cmd.load || i_cmd.ek_mod) begin
            r_rem  <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= w_trial[NW] ? {r_rem[NW-2:0], r_dq[KEY_W-1]} : w_trial[NW-1:0];
            r_mcnt <= r_mcnt + MC'(1);
        end
        if (i_cmd.probe_init) begin
            r_home <= IW'(r_rem);
            r_cur  <= IW'(r_rem);
            r_cnt  <= '0;
        end else if (i_cmd.advance) begin
            r_cur  <= w_nxt;
            r_cnt  <= r_cnt + IW'(1);
        end
        if (i_cmd.evict_cap) begin
            r_ek <= r_rd_key;
            r_ev <= r_rd_val;
        end
    end

    assign w_we = i_cmd.wr_new || i_cmd.wr_evict;
    assign w_wk = i_cmd.wr_evict ? r_ek : r_key;
    assign w_wv = i_cmd.wr_evict ? r_ev : r_val;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_key[r_cur] <= w_wk;
            r_mem_val[r_cur] <= w_wv;
        end
        r_rd_key <= r_mem_key[i_cmd.advance ? w_nxt : r_cur];
        r_rd_val <= r_mem_val[i_cmd.advance ? w_nxt : r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= '0;
        else if (w_we) r_valid[r_cur] <= 1'b1;
    end

    assign o_stat.mod_done = !r_mbusy;
    assign o_stat.func     = r_func;
    assign o_stat.cur_valid = r_valid[r_cur];
    assign o_stat.key_hit  = (r_rd_key == r_key);
    assign o_stat.rd_home  = (IW'(r_rem) == r_home);
    assign o_stat.last     = ({{(NW > IW ? NW - IW : 0){1'b0}}, r_cnt} ==
                              (NW > IW ? NW : IW)'(r_n - NW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_cmd.res_store || i_cmd.res_drop || i_cmd.res_drop_h ||
                     i_cmd.res_store_h || i_cmd.res_found || i_cmd.res_miss) begin
            o_res_valid <= 1'b1;
        end else if (i_res_take) begin
            o_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_store || i_cmd.res_store_h || i_cmd.res_drop ||
            i_cmd.res_drop_h || i_cmd.res_found || i_cmd.res_miss) begin
            o_found_value <= '0;
            o_comparisons <= '0;
            o_slot        <= '0;
            if (i_cmd.res_store) begin
                o_status <= ST_STORED;
                o_slot   <= SLOT_W'(r_cur);
            end else if (i_cmd.res_store_h) begin
                o_status <= ST_STORED;
                o_slot   <= SLOT_W'(r_home);
            end else if (i_cmd.res_drop) begin
                o_status <= ST_DROPPED;
            end else if (i_cmd.res_drop_h) begin
                o_status <= ST_DROPPED;
                o_slot   <= SLOT_W'(r_home);
            end else if (i_cmd.res_found) begin
                o_status      <= ST_FOUND;
                o_slot        <= SLOT_W'(r_cur);
                o_found_value <= r_rd_val;
                o_comparisons <= CMP_W'(r_cnt) + CMP_W'(1);
            end else begin
                o_status <= ST_MISS;
                if (r_func == FUNC_SEARCH) o_comparisons <= CMP_W'(r_n);
            end
        end
    end
endmodule
`default_nettype wire

/* tb/tb_linear_probing_hash_table.sv */
// Testbench for linear_probing_hash_table: random and directed words checked against a predictor.
`timescale 1ns / 100ps

import lpht_pkg::*;

typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
} t_in_word;

typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  found_value;
    logic [CMP_W-1:0]  comparisons;
} t_out_word;

class lookup_scoreboard;
    localparam int NSLOT = 16;
    logic [KEY_W-1:0] keys [NSLOT];
    logic [VAL_W-1:0] vals [NSLOT];
    bit               held [NSLOT];
    logic [CFG_W-1:0] size_reg;
    t_out_word        pending [$];
    int               errors;

    function new();
        foreach (held[i]) begin
            held[i] = 0;
            keys[i] = '0;
            vals[i] = '0;
        end
        size_reg = 5'd16;
        errors = 0;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
        size_reg = v;
    endfunction

    function int unsigned slots_in_use();
        if (size_reg < 1) return 1;
        if (size_reg > NSLOT) return NSLOT;
        return 32'(size_reg);
    endfunction

    function int free_after(int unsigned start, int unsigned n);
        for (int unsigned d = 1; d < n; d++) begin
            if (!held[(start + d) % n]) return int'((start + d) % n);
        end
        return -1;
    endfunction

    function void store(int unsigned s, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        keys[s] = k;
        vals[s] = v;
        held[s] = 1;
    endfunction

    function void note_word(t_in_word w);
        int unsigned n;
        int unsigned h;
        int          s;
        int unsigned p;
        logic [KEY_W-1:0] ek;
        logic [VAL_W-1:0] ev;
        t_out_word r;
        n = slots_in_use();
        h = 32'(w.key % KEY_W'(n));
        r = '{status: ST_MISS, slot: '0, found_value: '0, comparisons: '0};
        if (w.func == FUNC_INS || w.func == FUNC_INS_REPL) begin
            if (!held[h]) begin
                store(h, w.key, w.value);
                r.status = ST_STORED;
                r.slot = SLOT_W'(h);
            end else if (w.func == FUNC_INS || (keys[h] % KEY_W'(n)) == KEY_W'(h)) begin
                s = free_after(h, n);
                if (s >= 0) begin
                    store(unsigned'(s), w.key, w.value);
                    r.status = ST_STORED;
                    r.slot = SLOT_W'(s);
                end else begin
                    r.status = ST_DROPPED;
                end
            end else begin
                ek = keys[h];
                ev = vals[h];
                store(h, w.key, w.value);
                s = free_after(h, n);
                if (s >= 0) begin
                    store(unsigned'(s), ek, ev);
                    r.status = ST_STORED;
                end else begin
                    r.status = ST_DROPPED;
                end
                r.slot = SLOT_W'(h);
            end
        end else if (w.func == FUNC_SEARCH) begin
            r.comparisons = CMP_W'(n);
            for (int unsigned d = 0; d < n; d++) begin
                p = (h + d) % n;
                if (held[p] && keys[p] == w.key) begin
                    r.status = ST_FOUND;
                    r.slot = SLOT_W'(p);
                    r.found_value = vals[p];
                    r.comparisons = CMP_W'(d + 1);
                    break;
                end
            end
        end
        pending.push_back(r);
    endfunction

    function void check_word(t_out_word got);
        t_out_word exp_w;
        if (pending.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        if (got.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, got.status);
            errors++;
        end
        if (got.slot !== exp_w.slot) begin
            $error("slot: expected %0d, got %0d", exp_w.slot, got.slot);
            errors++;
        end
        if (got.found_value !== exp_w.found_value) begin
            $error("found_value: expected %h, got %h", exp_w.found_value, got.found_value);
            errors++;
        end
        if (got.comparisons !== exp_w.comparisons) begin
            $error("comparisons: expected %0d, got %0d", exp_w.comparisons, got.comparisons);
            errors++;
        end
    endfunction
endclass

module tb_linear_probing_hash_table;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    longint           cycles = 0;
    int               send_idle;
    int               recv_stall;
    lookup_scoreboard book;
    logic [KEY_W-1:0] known_keys [$];

    lpht_if #(.T(t_in_word))  in_ch ();
    lpht_if #(.T(t_out_word)) out_ch ();

    linear_probing_hash_table #(.SLOTS(16)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_in     (in_ch),
        .m_out    (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) book.note_word(in_ch.data);
        if (i_rst_n && out_ch.valid && out_ch.ready) book.check_word(out_ch.data);
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        book.set_size(v);
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
        if (f == FUNC_INS || f == FUNC_INS_REPL) known_keys.push_back(k);
        send_word('{func: f, key: k, value: v});
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && known_keys.size() != 0)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        if (r < 75) return KEY_W'($urandom_range(40));
        return {2'($urandom_range(3)), $urandom()};
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return FUNC_INS;
        if (r < 65) return FUNC_INS_REPL;
        if (r < 98) return FUNC_SEARCH;
        return 2'd3;
    endfunction

    initial begin
        logic [CFG_W-1:0] sizes [11];
        book = new();
        send_idle = 0;
        recv_stall = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(FUNC_INS, 34'd0, 32'd0);
        send_op(FUNC_INS, {KEY_W{1'b1}}, {VAL_W{1'b1}});
        send_op(FUNC_SEARCH, 34'd0, 32'd5);
        send_op(FUNC_SEARCH, {KEY_W{1'b1}}, 32'd0);
        send_op(FUNC_SEARCH, 34'd7, 32'd0);
        send_op(FUNC_INS_REPL, 34'd16, 32'hA5A5_5A5A);
        send_op(FUNC_INS, 34'd0, 32'h1234_5678);
        send_op(FUNC_SEARCH, 34'd0, 32'd0);
        send_op(FUNC_INS, 34'd17, 32'h0F0F_F0F0);
        send_op(FUNC_INS_REPL, 34'd1, 32'd77);
        send_op(FUNC_SEARCH, 34'd17, 32'd0);
        send_word('{func: 2'd3, key: 34'd5, value: 32'd9});
        write_size(5'd2);
        send_op(FUNC_INS, 34'd4, 32'd1);
        send_op(FUNC_INS_REPL, 34'd3, 32'd2);
        send_op(FUNC_INS_REPL, 34'd6, 32'd3);
        send_op(FUNC_SEARCH, 34'd16, 32'd0);
        write_size(5'd0);
        send_op(FUNC_INS, 34'd9, 32'd4);
        send_op(FUNC_SEARCH, 34'd0, 32'd0);

        sizes = '{5'd2, 5'd1, 5'd3, 5'd31, 5'd5, 5'd8, 5'd12, 5'd16, 5'd7, 5'd16, 5'd10};
        for (int ph = 0; ph < 11; ph++) begin
            write_size(ph == 10 ? 5'($urandom_range(31)) : sizes[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 80; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 80; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            for (int i = 0; i < 44; i++) begin
                if (ph == 3 && i < 4) drain();
                send_op(pick_func(), pick_key(), $urandom());
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
design/lpht_pkg.sv
design/lpht_if.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probing_hash_table.sv
tb/tb_linear_probing_hash_table.sv
